FILE: src/orb_pkg.sv
// Package for the open-row burst memory model.
// Holds the storage size, address field positions, phase codes and the
// structs passed between the control, output and memory parts.
package orb_pkg;

    localparam int WORD_INDEX_BITS = 16;
    localparam int STORE_WORDS     = 1 << WORD_INDEX_BITS;

    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 32;
    localparam int ROW_W   = 13;
    localparam int ROW_LSB = 11;
    localparam int BURST_W = 4;

    localparam logic [DATA_W-1:0]  FILL_MARK   = 32'h5500_0000;
    localparam logic [BURST_W-1:0] READ_FIRST  = 4'd0;
    localparam logic [BURST_W-1:0] WRITE_FIRST = 4'd1;
    localparam logic [BURST_W-1:0] STORE_FIRST = 4'd2;
    localparam logic [BURST_W-1:0] BURST_LAST  = 4'd8;
    localparam logic [BURST_W-1:0] WRITE_END   = 4'd9;

    localparam logic [WORD_INDEX_BITS-1:0] STORE_LAG = WORD_INDEX_BITS'(2);

    typedef logic [WORD_INDEX_BITS-1:0] t_word_idx;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ROW      = 4'd1,
        PH_ROW_WAIT = 4'd2,
        PH_READ     = 4'd3,
        PH_WRITE    = 4'd4,
        PH_LAT1     = 4'd5,
        PH_LAT2     = 4'd6,
        PH_READING  = 4'd7,
        PH_WRITING  = 4'd8
    } t_phase;

    typedef struct packed {
        logic wack;
        logic rack;
        logic done;
        logic cre;
        logic cwe;
    } t_flags;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_flags            flags;
        logic              load;
    } t_stage;

    typedef struct packed {
        logic              we;
        t_word_idx         waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        t_word_idx         raddr;
    } t_mem_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        t_flags            flags;
    } t_result;

endpackage

FILE: src/orb_if.sv
// Request and response channel interfaces of the burst memory model.
// Depends on orb_pkg for field widths.
interface orb_req_if import orb_pkg::*;;
    logic              valid;
    logic              ready;
    logic              read_request;
    logic              write_request;
    logic [ADDR_W-1:0] request_address;
    logic [DATA_W-1:0] cache_data;

    modport source (output valid, read_request, write_request, request_address,
                    cache_data, input ready);
    modport sink (input valid, read_request, write_request, request_address,
                  cache_data, output ready);
endinterface

interface orb_rsp_if import orb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] word_address;
    logic [DATA_W-1:0] read_word;
    logic              cache_write_enable;
    logic              cache_read_enable;
    logic              line_done;
    logic              read_ack;
    logic              write_ack;

    modport source (output valid, word_address, read_word, cache_write_enable,
                    cache_read_enable, line_done, read_ack, write_ack, input ready);
    modport sink (input valid, word_address, read_word, cache_write_enable,
                  cache_read_enable, line_done, read_ack, write_ack, output ready);
endinterface

FILE: src/orb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module orb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/orb_ctrl.sv
// Phase sequencer of the burst memory model: row tracking, burst counter,
// output flags and storage commands. Depends on orb_pkg.
module orb_ctrl import orb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_read_request,
    input  logic              i_write_request,
    input  logic [ADDR_W-1:0] i_request_address,
    input  logic [DATA_W-1:0] i_cache_data,
    output t_stage            o_stage,
    output t_mem_cmd          o_mem
);

    t_phase             r_phase, n_phase;
    logic [ROW_W-1:0]   r_open_row, n_open_row;
    logic [ADDR_W-1:0]  r_held, n_held;
    logic               r_is_write, n_is_write;
    logic [BURST_W-1:0] r_burst, n_burst;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;
    t_flags             r_flags, n_flags;

    logic [BURST_W-1:0] burst_inc;
    logic [ADDR_W-1:0]  burst_addr;
    logic               any_req;
    logic               row_hit;

    assign burst_inc  = r_burst + BURST_W'(1);
    assign burst_addr = r_held + {{(ADDR_W-BURST_W-2){1'b0}}, r_burst, 2'b00};
    assign any_req    = i_read_request | i_write_request;
    assign row_hit    = r_open_row == i_request_address[ROW_LSB +: ROW_W];

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_ROW:      n_phase = PH_ROW_WAIT;
            PH_ROW_WAIT: n_phase = r_is_write ? PH_WRITE : PH_READ;
            PH_READ:     n_phase = PH_LAT1;
            PH_WRITE:    n_phase = PH_WRITING;
            PH_LAT1:     n_phase = PH_LAT2;
            PH_LAT2:     n_phase = PH_READING;
            PH_READING: begin
                if (burst_inc == BURST_LAST) n_phase = PH_IDLE;
            end
            PH_WRITING: begin
                if (burst_inc == WRITE_END) n_phase = PH_IDLE;
            end
            default: begin
                if (!any_req) n_phase = PH_IDLE;
                else if (!row_hit) n_phase = PH_ROW;
                else n_phase = i_read_request ? PH_READ : PH_WRITE;
            end
        endcase
    end

    always_comb begin
        n_open_row = r_open_row;
        n_held     = r_held;
        n_is_write = r_is_write;
        n_burst    = r_burst;
        n_out_addr = r_out_addr;
        n_flags    = r_flags;
        o_mem      = '0;
        o_stage    = '0;
        unique case (r_phase)
            PH_ROW: n_open_row = r_held[ROW_LSB +: ROW_W];
            PH_ROW_WAIT, PH_LAT1, PH_LAT2: ;
            PH_READ: begin
                n_burst      = READ_FIRST;
                n_flags.rack = 1'b1;
            end
            PH_WRITE: begin
                n_burst      = WRITE_FIRST;
                n_flags.wack = 1'b1;
                n_flags.cre  = 1'b1;
                n_out_addr   = r_held;
            end
            PH_READING: begin
                n_flags.rack = 1'b0;
                n_flags.cwe  = 1'b1;
                n_out_addr   = burst_addr;
                n_burst      = burst_inc;
                o_stage.load = 1'b1;
                o_mem.re     = i_accept;
                o_mem.raddr  = burst_addr[2 +: WORD_INDEX_BITS];
                if (burst_inc == BURST_LAST) n_flags.done = 1'b1;
            end
            PH_WRITING: begin
                n_flags.wack = 1'b0;
                n_out_addr   = burst_addr;
                n_burst      = burst_inc;
                o_mem.we     = i_accept && (r_burst >= STORE_FIRST);
                o_mem.waddr  = burst_addr[2 +: WORD_INDEX_BITS] - STORE_LAG;
                o_mem.wdata  = i_cache_data;
                if (burst_inc == BURST_LAST) n_flags.done = 1'b1;
                if (burst_inc == WRITE_END) n_flags.done = 1'b0;
            end
            default: begin
                n_flags.cwe  = 1'b0;
                n_flags.cre  = 1'b0;
                n_flags.done = 1'b0;
                n_held       = i_request_address;
                if (any_req) n_is_write = !i_read_request;
            end
        endcase
        o_stage.addr  = n_out_addr;
        o_stage.flags = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_open_row <= '0;
            r_held     <= '0;
            r_is_write <= 1'b0;
            r_burst    <= '0;
            r_out_addr <= '0;
            r_flags    <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_open_row <= n_open_row;
            r_held     <= n_held;
            r_is_write <= n_is_write;
            r_burst    <= n_burst;
            r_out_addr <= n_out_addr;
            r_flags    <= n_flags;
        end
    end

endmodule

FILE: src/orb_outq.sv
// Two-stage response path: a pending stage that waits for the storage read
// data, then the response register. Depends on orb_pkg and orb_if.
module orb_outq import orb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_stage            i_stage,
    input  logic [DATA_W-1:0] i_rdata,
    output logic              o_can_take,
    orb_rsp_if.source         o_rsp
);

    logic    r_p_valid;
    t_stage  r_p;
    logic    r_o_valid;
    t_result r_o;
    logic    o_free;
    logic    p_move;

    assign o_free     = !r_o_valid || o_rsp.ready;
    assign p_move     = r_p_valid && o_free;
    assign o_can_take = !r_p_valid || o_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_o       <= '0;
        end else begin
            if (i_accept) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
                r_o.addr  <= r_p.addr;
                r_o.flags <= r_p.flags;
                if (r_p.load) r_o.data <= i_rdata;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p <= i_stage;
        end
    end

    assign o_rsp.valid              = r_o_valid;
    assign o_rsp.word_address       = r_o.addr;
    assign o_rsp.read_word          = r_o.data;
    assign o_rsp.cache_write_enable = r_o.flags.cwe;
    assign o_rsp.cache_read_enable  = r_o.flags.cre;
    assign o_rsp.line_done          = r_o.flags.done;
    assign o_rsp.read_ack           = r_o.flags.rack;
    assign o_rsp.write_ack          = r_o.flags.wack;

endmodule

FILE: src/open_row_burst_memory_model.sv
// Top level of the open-row burst memory model.
// Instantiates orb_ctrl, orb_outq and orb_ram; depends on orb_pkg and orb_if.
//
// Each request is one emulated DRAM clock tick and yields exactly one response
// carrying the registered memory port values after that tick. One request is
// taken every cycle unless the response path stalls or the fill is running;
// the response goes through the registered read port of the storage RAM and
// then the response register. After reset the storage is filled with its
// initial pattern, one word per cycle, over all 2^WORD_INDEX_BITS words (65536
// by default), and no request is taken until the fill ends.
module open_row_burst_memory_model import orb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    orb_req_if.sink   i_req,
    orb_rsp_if.source o_rsp
);

    logic              r_clearing;
    t_word_idx         r_clr_idx;
    logic              accept;
    logic              can_take;
    t_stage            stage;
    t_mem_cmd          mem;
    logic              ram_we;
    t_word_idx         ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    assign i_req.ready = !r_clearing && can_take;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + WORD_INDEX_BITS'(1);
            if (r_clr_idx == t_word_idx'(STORE_WORDS - 1)) r_clearing <= 1'b0;
        end
    end

    assign ram_we    = r_clearing || mem.we;
    assign ram_waddr = r_clearing ? r_clr_idx : mem.waddr;
    assign ram_wdata = r_clearing ? ((DATA_W'(r_clr_idx) << 2) | FILL_MARK) : mem.wdata;

    orb_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_read_request    (i_req.read_request),
        .i_write_request   (i_req.write_request),
        .i_request_address (i_req.request_address),
        .i_cache_data      (i_req.cache_data),
        .o_stage           (stage),
        .o_mem             (mem)
    );

    orb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (ram_rdata)
    );

    orb_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_stage    (stage),
        .i_rdata    (ram_rdata),
        .o_can_take (can_take),
        .o_rsp      (o_rsp)
    );

endmodule

FILE: test/orb_burst_checker.sv
// Response checker for the open-row burst memory model.
// Mirrors the DRAM phases, open row and storage per request, compares each response.
// Depends on orb_pkg and the channel interfaces in orb_if.
module orb_burst_checker import orb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    orb_req_if   i_req,
    orb_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] LINE_SPAN_MASK = 32'h03FF_FFFF;

    t_phase            phase;
    logic [ROW_W-1:0]  open_row;
    logic [ADDR_W-1:0] held_address;
    logic              op_is_write;
    logic [BURST_W-1:0] burst_index;
    logic [ADDR_W-1:0] port_address;
    logic [DATA_W-1:0] port_data;
    t_flags            port_flags;
    logic [DATA_W-1:0] dram_words [STORE_WORDS];

    t_result expected_ports [$];
    int      mismatch_count = 0;
    int      checked_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_checked    = checked_count;

    initial begin
        for (int k = 0; k < STORE_WORDS; k++)
            dram_words[k] = FILL_MARK | (DATA_W'(k) << 2);
    end

    function automatic t_word_idx word_slot(input logic [ADDR_W-1:0] addr,
                                            input t_word_idx lag);
        return t_word_idx'((addr & LINE_SPAN_MASK) >> 2) - lag;
    endfunction

    // Advance one emulated DRAM tick and return the registered port values.
    function automatic t_result dram_tick(input logic rd, input logic wr,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] cdata);
        t_result ports;
        case (phase)
            PH_ROW: begin
                open_row = held_address[ROW_LSB +: ROW_W];
                phase = PH_ROW_WAIT;
            end
            PH_ROW_WAIT: phase = op_is_write ? PH_WRITE : PH_READ;
            PH_READ: begin
                burst_index = READ_FIRST;
                port_flags.rack = 1'b1;
                phase = PH_LAT1;
            end
            PH_WRITE: begin
                burst_index = WRITE_FIRST;
                port_flags.wack = 1'b1;
                port_flags.cre = 1'b1;
                port_address = held_address;
                phase = PH_WRITING;
            end
            PH_LAT1: phase = PH_LAT2;
            PH_LAT2: phase = PH_READING;
            PH_READING: begin
                port_flags.rack = 1'b0;
                port_flags.cwe = 1'b1;
                port_address = held_address + {26'd0, burst_index, 2'b00};
                port_data = dram_words[word_slot(port_address, '0)];
                burst_index = burst_index + 1'b1;
                if (burst_index == BURST_LAST) begin
                    phase = PH_IDLE;
                    port_flags.done = 1'b1;
                end
            end
            PH_WRITING: begin
                port_flags.wack = 1'b0;
                port_address = held_address + {26'd0, burst_index, 2'b00};
                if (burst_index >= STORE_FIRST)
                    dram_words[word_slot(port_address, STORE_LAG)] = cdata;
                burst_index = burst_index + 1'b1;
                if (burst_index == BURST_LAST)
                    port_flags.done = 1'b1;
                if (burst_index == WRITE_END) begin
                    port_flags.done = 1'b0;
                    phase = PH_IDLE;
                end
            end
            default: begin
                port_flags.cwe = 1'b0;
                port_flags.cre = 1'b0;
                port_flags.done = 1'b0;
                held_address = addr;
                if (rd || wr) begin
                    if (open_row == addr[ROW_LSB +: ROW_W])
                        phase = rd ? PH_READ : PH_WRITE;
                    else
                        phase = PH_ROW;
                    op_is_write = !rd;
                end else begin
                    phase = PH_IDLE;
                end
            end
        endcase
        ports.addr = port_address;
        ports.data = port_data;
        ports.flags = port_flags;
        return ports;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            phase = PH_IDLE;
            open_row = '0;
            held_address = '0;
            op_is_write = 1'b0;
            burst_index = '0;
            port_address = '0;
            port_data = '0;
            port_flags = '0;
            expected_ports.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                expected_ports.push_back(dram_tick(i_req.read_request, i_req.write_request,
                                                   i_req.request_address, i_req.cache_data));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_ports.size() == 0) begin
                    $display("%0t: response with none expected, actual addr %h data %h",
                             $time, i_rsp.word_address, i_rsp.read_word);
                    mismatch_count++;
                end else begin
                    want = expected_ports.pop_front();
                    checked_count++;
                    compare_field("word_address", want.addr, i_rsp.word_address);
                    compare_field("read_word", want.data, i_rsp.read_word);
                    compare_field("cache_write_enable", 32'(want.flags.cwe),
                                  32'(i_rsp.cache_write_enable));
                    compare_field("cache_read_enable", 32'(want.flags.cre),
                                  32'(i_rsp.cache_read_enable));
                    compare_field("line_done", 32'(want.flags.done), 32'(i_rsp.line_done));
                    compare_field("read_ack", 32'(want.flags.rack), 32'(i_rsp.read_ack));
                    compare_field("write_ack", 32'(want.flags.wack), 32'(i_rsp.write_ack));
                end
            end
        end
        o_pending <= expected_ports.size();
    end

endmodule

FILE: test/tb_top.sv
// Top-level testbench for the open-row burst memory model.
// Drives tick requests in bursts, stalls responses, and gives the verdict;
// depends on orb_pkg, orb_if and orb_burst_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import orb_pkg::*;

    localparam int TICK_TARGET = 1950;
    localparam int DRAIN_EVERY = 480;
    localparam int IDLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES = 8;
    localparam int POOL_SIZE   = 8;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    orb_req_if req_ch();
    orb_rsp_if rsp_ch();

    int fail_count;
    int pending;
    int checked;
    int ticks_sent = 0;
    int cmds_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int rx_left = 0;
    int rx_beat = 0;
    t_rx_mode rx_mode = RX_OPEN;
    logic [ADDR_W-1:0] line_pool [POOL_SIZE];

    open_row_burst_memory_model dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    orb_burst_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_left <= $urandom_range(40, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_beat <= rx_beat + 1;
        case (rx_mode)
            RX_OPEN: rsp_ch.ready <= 1'b1;
            RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= (rx_beat % 7) < 4;
        endcase
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[open_row_burst_memory_model] ERROR");
            $finish;
        end
    end

    // Send one tick; open a new burst, possibly after a gap, when the last one ran out.
    task automatic send_tick(input logic rd, input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.read_request <= rd;
        req_ch.write_request <= wr;
        req_ch.request_address <= addr;
        req_ch.cache_data <= data;
        do @(posedge i_clk); while (!req_ch.ready);
        ticks_sent++;
    endtask

    // Issue a line request tick, then fill ticks that carry write data or noise.
    task automatic line_cmd(input logic rd, input logic wr, input logic [ADDR_W-1:0] addr,
                            input int fill, input bit extreme_data);
        send_tick(rd, wr, addr, $urandom);
        cmds_sent++;
        for (int k = 0; k < fill; k++) begin
            if (extreme_data)
                send_tick(1'b0, 1'b0, $urandom, k[0] ? '1 : '0);
            else
                send_tick($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                          $urandom, $urandom);
        end
    endtask

    // Hold requests until every outstanding response has arrived.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int kind;
        int fill;
        int next_drain;
        logic rd;
        logic wr;
        logic [ADDR_W-1:0] addr;

        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.read_request = 1'b0;
        req_ch.write_request = 1'b0;
        req_ch.request_address = '0;
        req_ch.cache_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < POOL_SIZE; k++) begin
            line_pool[k] = $urandom;
            case (k % 4)
                0: line_pool[k][ROW_LSB +: ROW_W] = '0;
                1: line_pool[k][ROW_LSB +: ROW_W] = '1;
                2: line_pool[k][ROW_LSB +: ROW_W] = 13'd1;
                default: ;
            endcase
        end

        line_cmd(1'b0, 1'b0, 32'hFFFF_FFFF, 2, 1'b1);
        line_cmd(1'b1, 1'b0, 32'h0000_0000, 14, 1'b1);
        line_cmd(1'b0, 1'b1, 32'h03FF_FFF8, 14, 1'b1);
        line_cmd(1'b1, 1'b0, 32'h03FF_FFF8, 14, 1'b1);
        line_cmd(1'b1, 1'b1, 32'hFFFF_FFF0, 14, 1'b1);
        line_cmd(1'b0, 1'b1, 32'hFFFF_FFF0, 14, 1'b1);
        line_cmd(1'b1, 1'b0, 32'hFFFF_FFF0, 14, 1'b1);
        line_cmd(1'b0, 1'b1, 32'h0000_0800, 14, 1'b1);
        line_cmd(1'b1, 1'b0, 32'h0000_0804, 14, 1'b1);
        drain_responses();

        next_drain = ticks_sent + DRAIN_EVERY;
        while (ticks_sent < TICK_TARGET) begin
            kind = $urandom_range(0, 9);
            rd = (kind <= 3) || (kind == 7) || (kind == 9);
            wr = (kind >= 4) && (kind <= 7);
            addr = ($urandom_range(0, 9) < 7) ? line_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : $urandom;
            fill = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(10, 14);
            line_cmd(rd, wr, addr, fill, 1'b0);
            if (ticks_sent >= next_drain) begin
                drain_responses();
                next_drain += DRAIN_EVERY;
            end
        end

        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d ticks with %0d line requests (reads, writes, row hits",
                 ticks_sent, cmds_sent);
        $display("and misses, wrapped addresses); %0d responses checked.", checked);
        if (fail_count == 0)
            $display("[open_row_burst_memory_model] OK");
        else
            $display("[open_row_burst_memory_model] ERROR");
        $finish;
    end

endmodule
